FILE: hw/rtl/qrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrc_pkg: shared types and constants
// Beat formats, configuration register map, multiplier operand selects and
// the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package qrc_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int GAIN_W    = 32;
  localparam int DUTY_W    = 16;
  localparam int ACC_W     = 64;
  localparam int MUL_W     = 33;
  localparam int DATA_FRAC = 16;
  localparam int DUTY_FRAC = 15;
  localparam int CFG_IDX_W = 3;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN    = 3'd6;

  // multiplier operand pairs
  localparam logic [2:0] SEL_B0   = 3'd0;
  localparam logic [2:0] SEL_B1   = 3'd1;
  localparam logic [2:0] SEL_B2   = 3'd2;
  localparam logic [2:0] SEL_A1   = 3'd3;
  localparam logic [2:0] SEL_A2   = 3'd4;
  localparam logic [2:0] SEL_DUTY = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_value;
    logic signed [DATA_W-1:0] measured_value;
    logic signed [DATA_W-1:0] feed_forward;
  } qrc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_clamped;
    logic signed [DUTY_W-1:0] duty_scaled;
    logic                     clamp_active;
  } qrc_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic [LIMIT_W-1:0]       clamp_limit;
    logic [GAIN_W-1:0]        out_gain;
  } qrc_cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       calc_err;
    logic       acc_clear;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_en;
    logic       acc_sub;
    logic       calc_y;
    logic       calc_drv;
    logic       load_out;
  } qrc_cmd_t;

endpackage

FILE: hw/rtl/quasi_resonant_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quasi_resonant_controller_core: quasi-PR controller step
// Error, second-order resonant filter, feedforward, clamp and duty scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   (in_valid/in_ready, in_data): one sample beat holding
//                target, measurement and feedforward, all Q16.16.
//   out channel  (out_valid/out_ready, out_data): one result beat per
//                sample: clamped drive, Q1.15 duty and the clamp flag.
//   cfg port     (cfg_we/cfg_index/cfg_wdata): coefficient, limit and gain
//                registers; the user writes them only while no sample is
//                in flight, which the block itself does not enforce.
//   A sample occupies the block until its result is loaded, as the five
//   filter products and the duty product go one by one through a single
//   shared multiplier. The next input beat is taken while the last result
//   beat waits. Stall: if out_ready stays low, the next sample runs to its
//   final step and holds there until the pending result beat is taken.
//   Reset: the state, output valid, configuration and filter history
//   registers go to zero; no beat is pending afterwards.
// ----------------------------------------------------------------------------
module quasi_resonant_controller_core #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qrc_pkg::qrc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qrc_pkg::qrc_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [qrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrc_pkg::COEF_W-1:0]          cfg_wdata
);

  qrc_pkg::qrc_cmd_t cmd;
  qrc_pkg::qrc_cfg_t cfg;

  logic signed [qrc_pkg::COEF_W-1:0] coef_b0;
  logic signed [qrc_pkg::COEF_W-1:0] coef_b1;
  logic signed [qrc_pkg::COEF_W-1:0] coef_b2;
  logic signed [qrc_pkg::COEF_W-1:0] coef_a1;
  logic signed [qrc_pkg::COEF_W-1:0] coef_a2;
  logic [qrc_pkg::LIMIT_W-1:0]       clamp_limit;
  logic [qrc_pkg::GAIN_W-1:0]        out_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0     <= '0;
      coef_b1     <= '0;
      coef_b2     <= '0;
      coef_a1     <= '0;
      coef_a2     <= '0;
      clamp_limit <= '0;
      out_gain    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qrc_pkg::REG_COEF_B0:     coef_b0     <= cfg_wdata;
        qrc_pkg::REG_COEF_B1:     coef_b1     <= cfg_wdata;
        qrc_pkg::REG_COEF_B2:     coef_b2     <= cfg_wdata;
        qrc_pkg::REG_COEF_A1:     coef_a1     <= cfg_wdata;
        qrc_pkg::REG_COEF_A2:     coef_a2     <= cfg_wdata;
        qrc_pkg::REG_CLAMP_LIMIT: clamp_limit <= cfg_wdata[qrc_pkg::LIMIT_W-1:0];
        qrc_pkg::REG_OUT_GAIN:    out_gain    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg.coef_b0     = coef_b0;
  assign cfg.coef_b1     = coef_b1;
  assign cfg.coef_b2     = coef_b2;
  assign cfg.coef_a1     = coef_a1;
  assign cfg.coef_a2     = coef_a2;
  assign cfg.clamp_limit = clamp_limit;
  assign cfg.out_gain    = out_gain;

  qrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  qrc_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // one sample at a time: busy right after an input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // a fresh result is only loaded on the way back to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded without returning to idle");

  // a negative drive never scales to a positive duty
  a_duty_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_clamped[qrc_pkg::DATA_W-1] |->
      out_data.duty_scaled[qrc_pkg::DUTY_W-1] || (out_data.duty_scaled == '0))
    else $error("duty sign disagrees with drive sign");

endmodule

FILE: hw/rtl/qrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrc_ctrl: step sequencer
// Walks one sample through error, five multiply-accumulates, filter output,
// feedforward/clamp and duty scaling, and owns the output valid flag.
// ----------------------------------------------------------------------------
module qrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output qrc_pkg::qrc_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_M0   = 4'd2;
  localparam logic [3:0] ST_M1   = 4'd3;
  localparam logic [3:0] ST_M2   = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_M4   = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_Y    = 4'd8;
  localparam logic [3:0] ST_DRV  = 4'd9;
  localparam logic [3:0] ST_DMUL = 4'd10;
  localparam logic [3:0] ST_DOUT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err  = 1'b1;
        cmd.acc_clear = 1'b1;
        state_next    = ST_M0;
      end
      ST_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrc_pkg::SEL_B0;
        state_next  = ST_M1;
      end
      // each multiply overlaps the accumulate of the previous product
      ST_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrc_pkg::SEL_B1;
        cmd.acc_en  = 1'b1;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrc_pkg::SEL_B2;
        cmd.acc_en  = 1'b1;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrc_pkg::SEL_A1;
        cmd.acc_en  = 1'b1;
        state_next  = ST_M4;
      end
      ST_M4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrc_pkg::SEL_A2;
        cmd.acc_en  = 1'b1;
        cmd.acc_sub = 1'b1;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sub = 1'b1;
        state_next  = ST_Y;
      end
      ST_Y: begin
        cmd.calc_y = 1'b1;
        state_next = ST_DRV;
      end
      ST_DRV: begin
        cmd.calc_drv = 1'b1;
        state_next   = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrc_pkg::SEL_DUTY;
        state_next  = ST_DOUT;
      end
      ST_DOUT: begin
        // hold here while the previous result beat is still waiting
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/qrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrc_datapath: filter arithmetic
// One shared 33x33 multiplier, a saturating 64-bit accumulator, the error
// and output history, clamp and duty scaling, and the result register.
// ----------------------------------------------------------------------------
module qrc_datapath #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  qrc_pkg::qrc_cmd_t cmd,
  input  qrc_pkg::qrc_cfg_t cfg,
  input  qrc_pkg::qrc_in_t  in_data,
  output qrc_pkg::qrc_out_t out_data
);

  localparam int DW        = qrc_pkg::DATA_W;
  localparam int AW        = qrc_pkg::ACC_W;
  localparam int MW        = qrc_pkg::MUL_W;
  localparam int DUW       = qrc_pkg::DUTY_W;
  localparam int DUTY_SHIFT = qrc_pkg::DATA_FRAC + COEF_FRAC_BITS - qrc_pkg::DUTY_FRAC;

  qrc_pkg::qrc_in_t in_reg;

  logic signed [DW-1:0]   err;
  logic signed [DW-1:0]   err_prev_one;
  logic signed [DW-1:0]   err_prev_two;
  logic signed [DW-1:0]   filter_prev_one;
  logic signed [DW-1:0]   filter_prev_two;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   prod;
  logic signed [DW-1:0]   clamped;
  logic                   active;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] mul_full;

  logic signed [DW:0]     diff;
  logic signed [DW-1:0]   err_sat;
  logic signed [AW:0]     acc_sum;
  logic signed [AW-1:0]   acc_sat;
  logic signed [AW-1:0]   y_shift;
  logic signed [DW-1:0]   y_sat;
  logic signed [DW:0]     drv_sum;
  logic signed [DW:0]     drive;
  logic signed [DW:0]     lim_pos;
  logic signed [DW:0]     lim_neg;
  logic signed [DW-1:0]   clamped_next;
  logic                   active_next;
  logic signed [AW-1:0]   duty_shift;
  logic signed [DUW-1:0]  duty_sat;

  // error with saturation
  assign diff    = {in_reg.target_value[DW-1], in_reg.target_value}
                 - {in_reg.measured_value[DW-1], in_reg.measured_value};
  assign err_sat = (diff[DW] != diff[DW-1])
                 ? {diff[DW], {(DW-1){!diff[DW]}}} : diff[DW-1:0];

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      qrc_pkg::SEL_B0: begin
        mul_a = {cfg.coef_b0[DW-1], cfg.coef_b0};
        mul_b = {err[DW-1], err};
      end
      qrc_pkg::SEL_B1: begin
        mul_a = {cfg.coef_b1[DW-1], cfg.coef_b1};
        mul_b = {err_prev_one[DW-1], err_prev_one};
      end
      qrc_pkg::SEL_B2: begin
        mul_a = {cfg.coef_b2[DW-1], cfg.coef_b2};
        mul_b = {err_prev_two[DW-1], err_prev_two};
      end
      qrc_pkg::SEL_A1: begin
        mul_a = {cfg.coef_a1[DW-1], cfg.coef_a1};
        mul_b = {filter_prev_one[DW-1], filter_prev_one};
      end
      qrc_pkg::SEL_A2: begin
        mul_a = {cfg.coef_a2[DW-1], cfg.coef_a2};
        mul_b = {filter_prev_two[DW-1], filter_prev_two};
      end
      qrc_pkg::SEL_DUTY: begin
        mul_a = {1'b0, cfg.out_gain};
        mul_b = {clamped[DW-1], clamped};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // saturating accumulate, feedback terms are subtracted
  assign acc_sum = cmd.acc_sub ? ({acc[AW-1], acc} - {prod[AW-1], prod})
                               : ({acc[AW-1], acc} + {prod[AW-1], prod});
  assign acc_sat = (acc_sum[AW] != acc_sum[AW-1])
                 ? {acc_sum[AW], {(AW-1){!acc_sum[AW]}}} : acc_sum[AW-1:0];

  // floor shift back to data format, then saturate
  assign y_shift = acc >>> COEF_FRAC_BITS;
  assign y_sat   = (y_shift[AW-1:DW-1] != {(AW-DW+1){y_shift[AW-1]}})
                 ? {y_shift[AW-1], {(DW-1){!y_shift[AW-1]}}} : y_shift[DW-1:0];

  // feedforward and symmetric clamp
  assign drv_sum = {filter_prev_one[DW-1], filter_prev_one}
                 + {in_reg.feed_forward[DW-1], in_reg.feed_forward};
  assign drive   = (drv_sum[DW] != drv_sum[DW-1])
                 ? {drv_sum[DW], drv_sum[DW], {(DW-1){!drv_sum[DW]}}}
                 : drv_sum;
  assign lim_pos = {2'b00, cfg.clamp_limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (drive > lim_pos) begin
      clamped_next = lim_pos[DW-1:0];
      active_next  = 1'b1;
    end else if (drive < lim_neg) begin
      clamped_next = lim_neg[DW-1:0];
      active_next  = 1'b1;
    end else begin
      clamped_next = drive[DW-1:0];
      active_next  = 1'b0;
    end
  end

  // duty: floor shift to Q1.15 and saturate
  assign duty_shift = prod >>> DUTY_SHIFT;
  assign duty_sat   = (duty_shift[AW-1:DUW-1] != {(AW-DUW+1){duty_shift[AW-1]}})
                    ? {duty_shift[AW-1], {(DUW-1){!duty_shift[AW-1]}}}
                    : duty_shift[DUW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      err_prev_one    <= '0;
      err_prev_two    <= '0;
      filter_prev_one <= '0;
      filter_prev_two <= '0;
    end else if (cmd.calc_y) begin
      err_prev_two    <= err_prev_one;
      err_prev_one    <= err;
      filter_prev_two <= filter_prev_one;
      filter_prev_one <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= in_data;
    end
    if (cmd.calc_err) begin
      err <= err_sat;
    end
    if (cmd.mul_en) begin
      prod <= mul_full[AW-1:0];
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc_sat;
    end
    if (cmd.calc_drv) begin
      clamped <= clamped_next;
      active  <= active_next;
    end
    if (cmd.load_out) begin
      out_data.drive_clamped <= clamped;
      out_data.duty_scaled   <= duty_sat;
      out_data.clamp_active  <= active;
    end
  end

endmodule

FILE: tb/tb_quasi_resonant_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quasi_resonant_controller_core: self-checking bench for the quasi-PR core
// Drives sample beats under random idling and stalls, writes the coefficient,
// limit and gain registers between phases, and checks every result beat
// against the bit-exact error/filter/clamp/duty predictor or a known row.
// ----------------------------------------------------------------------------
module tb_quasi_resonant_controller_core;

  localparam int COEF_FRAC_BITS = 24;
  localparam int LATENCY = 12;
  localparam int N_PHASES = 10;
  localparam int SAMPLES_PER_PHASE = 130;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // index past the register map, must be ignored by the block
  localparam logic [qrc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [65:0] DATA_HI = 66'sd2147483647;
  localparam logic signed [65:0] DATA_LO = -66'sd2147483648;
  localparam logic signed [65:0] ACC_HI = (66'sd1 <<< 63) - 66'sd1;
  localparam logic signed [65:0] ACC_LO = -(66'sd1 <<< 63);
  localparam logic signed [65:0] DUTY_HI = 66'sd32767;
  localparam logic signed [65:0] DUTY_LO = -66'sd32768;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic [qrc_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [qrc_pkg::COEF_W-1:0]        reg_val;
    qrc_pkg::qrc_in_t                  smp;
    qrc_pkg::qrc_out_t                 want;
  } row_t;

  localparam int N_DIR = 31;

  // known rows: reset settings give zero output, zero limit clamps any nonzero
  // drive, and the saturated error with unit b0 hits both clamp ends
  localparam row_t DIRECTED [N_DIR] = '{
    '{ROW_KNOWN, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, '{32'h0, 16'h0, 1'b0}},
    '{ROW_KNOWN, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h1234_5678, 32'h0ABC_DEF0, 32'h7FFF_FFFF}, '{32'h0, 16'h0, 1'b1}},
    '{ROW_KNOWN, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, '{32'h0, 16'h0, 1'b1}},
    '{ROW_WRITE, qrc_pkg::REG_COEF_B0, 32'h0100_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_CLAMP_LIMIT, 32'h7FFF_FFFF, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_OUT_GAIN, 32'hFFFF_FFFF, '0, '0},
    '{ROW_KNOWN, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
      '{32'h7FFF_FFFF, 16'h7FFF, 1'b0}},
    '{ROW_KNOWN, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000},
      '{32'h8000_0001, 16'h8000, 1'b1}},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h8000_0000, 32'h0000_0000, 32'h8000_0000}, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_B1, 32'h7FFF_FFFF, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_B2, 32'h8000_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_A1, 32'h8000_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_A2, 32'h7FFF_FFFF, '0, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000}, '0},
    '{ROW_WRITE, qrc_pkg::REG_CLAMP_LIMIT, 32'h8001_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_OUT_GAIN, 32'h00F3_3333, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_B1, 32'h0000_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_B2, 32'h0000_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_A1, 32'hFF00_0000, '0, '0},
    '{ROW_WRITE, qrc_pkg::REG_COEF_A2, 32'h0000_0000, '0, '0},
    '{ROW_WRITE, REG_SPARE, 32'hFFFF_FFFF, '0, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0000_8000, 32'h0000_0000, 32'h0000_0000}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0000_8000, 32'h0000_0000, 32'h0000_0000}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0000_8000, 32'h0000_0000, 32'h0000_0000}, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'hFFFF_8000, 32'h0003_0001, 32'h8000_0000}, '0},
    '{ROW_WRITE, qrc_pkg::REG_OUT_GAIN, 32'h0000_0000, '0, '0},
    '{ROW_SAMPLE, qrc_pkg::REG_COEF_B0, 32'h0,
      '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF}, '0}
  };

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  qrc_pkg::qrc_in_t               in_data;
  logic                           out_valid;
  logic                           out_ready;
  qrc_pkg::qrc_out_t              out_data;
  logic                           cfg_we;
  logic [qrc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qrc_pkg::COEF_W-1:0]     cfg_wdata;

  quasi_resonant_controller_core #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the registers and the filter history
  logic signed [qrc_pkg::COEF_W-1:0] coef_b0_q = '0;
  logic signed [qrc_pkg::COEF_W-1:0] coef_b1_q = '0;
  logic signed [qrc_pkg::COEF_W-1:0] coef_b2_q = '0;
  logic signed [qrc_pkg::COEF_W-1:0] coef_a1_q = '0;
  logic signed [qrc_pkg::COEF_W-1:0] coef_a2_q = '0;
  logic [qrc_pkg::LIMIT_W-1:0]       limit_q = '0;
  logic [qrc_pkg::GAIN_W-1:0]        gain_q = '0;
  logic signed [65:0]                err_z1 = '0;
  logic signed [65:0]                err_z2 = '0;
  logic signed [65:0]                flt_z1 = '0;
  logic signed [65:0]                flt_z2 = '0;

  qrc_pkg::qrc_out_t result_q [$];
  int                send_idle_pct = 37;
  int                recv_idle_pct = 67;
  int                hold_cycles = 0;
  int                fail_count = 0;
  int                samples_sent = 0;
  int                results_seen = 0;
  int                clamp_hits = 0;
  int                settings_loaded = 0;
  int unsigned       cycle_count = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [65:0] clip(input logic signed [65:0] v,
                                               input logic signed [65:0] lo,
                                               input logic signed [65:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one controller step: error, resonant filter, feedforward, clamp, duty
  function automatic qrc_pkg::qrc_out_t qpr_step(input qrc_pkg::qrc_in_t s);
    logic signed [65:0] tv, mv, ffv, err, acc, y, drive, lim, clamped, duty;
    logic               act;
    qrc_pkg::qrc_out_t  r;
    tv = $signed(s.target_value);
    mv = $signed(s.measured_value);
    ffv = $signed(s.feed_forward);
    err = clip(tv - mv, DATA_LO, DATA_HI);
    acc = coef_b0_q * err;
    acc = clip(acc + coef_b1_q * err_z1, ACC_LO, ACC_HI);
    acc = clip(acc + coef_b2_q * err_z2, ACC_LO, ACC_HI);
    acc = clip(acc - coef_a1_q * flt_z1, ACC_LO, ACC_HI);
    acc = clip(acc - coef_a2_q * flt_z2, ACC_LO, ACC_HI);
    y = clip(acc >>> COEF_FRAC_BITS, DATA_LO, DATA_HI);
    err_z2 = err_z1;
    err_z1 = err;
    flt_z2 = flt_z1;
    flt_z1 = y;
    drive = clip(y + ffv, DATA_LO, DATA_HI);
    lim = $signed({35'd0, limit_q});
    act = 1'b1;
    if (drive > lim) clamped = lim;
    else if (drive < -lim) clamped = -lim;
    else begin
      clamped = drive;
      act = 1'b0;
    end
    duty = clip((clamped * $signed({34'd0, gain_q})) >>>
                (qrc_pkg::DATA_FRAC + COEF_FRAC_BITS - qrc_pkg::DUTY_FRAC),
                DUTY_LO, DUTY_HI);
    r.drive_clamped = clamped[qrc_pkg::DATA_W-1:0];
    r.duty_scaled = duty[qrc_pkg::DUTY_W-1:0];
    r.clamp_active = act;
    return r;
  endfunction

  task automatic send_sample(input qrc_pkg::qrc_in_t s, input logic use_want,
                             input qrc_pkg::qrc_out_t want);
    qrc_pkg::qrc_out_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = s;
    do @(posedge clk); while (!in_ready);
    pred = qpr_step(s);
    result_q.push_back(use_want ? want : pred);
    samples_sent++;
  endtask

  // drop valid and let every outstanding result beat come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qrc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qrc_pkg::COEF_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      qrc_pkg::REG_COEF_B0:     coef_b0_q = val;
      qrc_pkg::REG_COEF_B1:     coef_b1_q = val;
      qrc_pkg::REG_COEF_B2:     coef_b2_q = val;
      qrc_pkg::REG_COEF_A1:     coef_a1_q = val;
      qrc_pkg::REG_COEF_A2:     coef_a2_q = val;
      qrc_pkg::REG_CLAMP_LIMIT: limit_q = val[qrc_pkg::LIMIT_W-1:0];
      qrc_pkg::REG_OUT_GAIN:    gain_q = val;
      default: ;
    endcase
  endtask

  function automatic logic [qrc_pkg::COEF_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'h0100_0000;
    endcase
  endfunction

  // mostly small Q16.16 values, some full-range words and the two extremes
  function automatic logic [qrc_pkg::DATA_W-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    if (r < 9) return $urandom;
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  task automatic load_random_setting();
    logic [qrc_pkg::COEF_W-1:0] b0, b1, b2, a1, a2, lim, gain;
    int unsigned                style;
    style = $urandom_range(0, 9);
    if (style < 4) begin
      // lightly damped resonator near the stability edge
      b0 = $urandom_range(0, 32'h0100_0000);
      b1 = 32'h0;
      b2 = -b0;
      a1 = -(32'h01F0_0000 + 32'($urandom_range(0, 32'h000F_FFFF)));
      a2 = 32'h00F0_0000 + 32'($urandom_range(0, 32'h000F_FFFF));
    end else if (style < 6) begin
      b0 = $urandom_range(0, 32'h0400_0000);
      b1 = 32'h0;
      b2 = 32'h0;
      a1 = 32'h0;
      a2 = 32'h0;
    end else if (style < 8) begin
      b0 = $urandom;
      b1 = $urandom;
      b2 = $urandom;
      a1 = $urandom;
      a2 = $urandom;
    end else begin
      b0 = pick_extreme();
      b1 = pick_extreme();
      b2 = pick_extreme();
      a1 = pick_extreme();
      a2 = pick_extreme();
    end
    case ($urandom_range(0, 4))
      0: lim = $urandom;
      1, 2: lim = $urandom_range(0, 32'h0008_0000);
      3: lim = 32'h0;
      default: lim = 32'h7FFF_FFFF;
    endcase
    case ($urandom_range(0, 4))
      0: gain = $urandom;
      1, 2: gain = $urandom_range(0, 32'h0200_0000);
      3: gain = 32'h0;
      default: gain = 32'hFFFF_FFFF;
    endcase
    write_reg(qrc_pkg::REG_COEF_B0, b0);
    write_reg(qrc_pkg::REG_COEF_B1, b1);
    write_reg(qrc_pkg::REG_COEF_B2, b2);
    write_reg(qrc_pkg::REG_COEF_A1, a1);
    write_reg(qrc_pkg::REG_COEF_A2, a2);
    write_reg(qrc_pkg::REG_CLAMP_LIMIT, lim);
    write_reg(qrc_pkg::REG_OUT_GAIN, gain);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, $urandom);
    settings_loaded++;
  endtask

  // receiver: random back-pressure, plus long hold-offs when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    qrc_pkg::qrc_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.clamp_active) clamp_hits++;
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: drive_clamped %0d",
               out_data.drive_clamped);
        fail_count++;
      end else begin
        want = result_q.pop_front();
        if (out_data.drive_clamped !== want.drive_clamped) begin
          $error("drive_clamped: expected %0d, got %0d",
                 want.drive_clamped, out_data.drive_clamped);
          fail_count++;
        end
        if (out_data.duty_scaled !== want.duty_scaled) begin
          $error("duty_scaled: expected %0d, got %0d",
                 want.duty_scaled, out_data.duty_scaled);
          fail_count++;
        end
        if (out_data.clamp_active !== want.clamp_active) begin
          $error("clamp_active: expected %0b, got %0b",
                 want.clamp_active, out_data.clamp_active);
          fail_count++;
        end
      end
    end
  end

  initial begin
    qrc_pkg::qrc_in_t s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        send_sample(DIRECTED[i].smp, DIRECTED[i].kind == ROW_KNOWN, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      if (ph < 4) begin
        send_idle_pct = 37;
        recv_idle_pct = 67;
      end else if (ph < 7) begin
        send_idle_pct = 67;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_random_setting();
      // long receiver hold-off so the core fills and stalls its input
      if (ph == 2 || ph == 8) hold_cycles = 400;
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        s.target_value = pick_data();
        // measurement usually tracks the set point closely
        if ($urandom_range(0, 3) != 0)
          s.measured_value = s.target_value + 32'($urandom_range(0, 32'h0002_0000))
                             - 32'h0001_0000;
        else
          s.measured_value = pick_data();
        s.feed_forward = pick_data();
        send_sample(s, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (2 * LATENCY) @(posedge clk);
    $display("summary: %0d samples over %0d random settings, %0d results checked",
             samples_sent, settings_loaded, results_seen);
    $display("summary: %0d results clamped, %0d mismatches", clamp_hits, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/qrc_pkg.sv
hw/rtl/qrc_ctrl.sv
hw/rtl/qrc_datapath.sv
hw/rtl/quasi_resonant_controller_core.sv
tb/tb_quasi_resonant_controller_core.sv
